>>> rtl/core/dbam_pkg.sv
// Package for the disk block availability map: constants, item/result types,
// controller/datapath interface structs and the zone sector mask function.
// No dependencies.
`default_nettype none

package dbam_pkg;

    localparam int TRACK_LIMIT = 35;
    localparam int TRK_W       = 6;
    localparam int SEC_W       = 5;
    localparam int IDX_W       = $clog2(TRACK_LIMIT);
    localparam int MAP_BITS    = 24;
    localparam int CNT_W       = 8;
    localparam int TOT_W       = 14;
    localparam int ENTRY_W     = CNT_W + MAP_BITS;
    localparam int DIR_TRACK   = 18;

    localparam logic [2:0] KIND_QUERY = 3'd0;
    localparam logic [2:0] KIND_ALLOC = 3'd1;
    localparam logic [2:0] KIND_FREE  = 3'd2;
    localparam logic [2:0] KIND_FIND  = 3'd3;
    localparam logic [2:0] KIND_LOAD  = 3'd4;

    localparam logic [1:0] LIDX_COUNT = 2'd0;
    localparam logic [1:0] LIDX_BYTE0 = 2'd1;
    localparam logic [1:0] LIDX_BYTE1 = 2'd2;
    localparam logic [1:0] LIDX_BYTE2 = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NOFREE = 2'd2;

    typedef struct packed {
        logic [2:0]       kind;
        logic [TRK_W-1:0] track;
        logic [SEC_W-1:0] sector;
        logic [1:0]       load_index;
        logic [7:0]       load_value;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic             is_free;
        logic [TRK_W-1:0] found_track;
        logic [SEC_W-1:0] found_sector;
        logic [CNT_W-1:0] track_free_count;
        logic [TOT_W-1:0] total_free;
    } t_result;

    typedef struct packed {
        logic accept;       // item taken, first read issued if a search or track in range
        logic exec;         // entry data ready, apply operation
        logic scan_step;    // read next track entry
        logic scan_finish;  // close the search, emit result
    } t_dp_cmd;

    typedef struct packed {
        logic in_find;      // item at the port is a search
        logic scan_hit;     // entry under test has a free sector
        logic scan_last;    // entry under test is the last track
    } t_dp_stat;

    // Sectors that exist on a track; the directory track is left out of the search.
    function automatic logic [MAP_BITS-1:0] zone_mask(input logic [TRK_W-1:0] trk);
        logic [MAP_BITS-1:0] m;
        if (trk == TRK_W'(DIR_TRACK))      m = '0;
        else if (trk < TRK_W'(18))         m = 24'h1F_FFFF;
        else if (trk < TRK_W'(25))         m = 24'h07_FFFF;
        else if (trk < TRK_W'(31))         m = 24'h03_FFFF;
        else                               m = 24'h01_FFFF;
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dbam_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dbam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 35
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dbam_ctrl.sv
// Controller FSM: sequences accept, execute and the track search.
// Depends on dbam_pkg.
`default_nettype none

module dbam_ctrl
    import dbam_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = i_stat.in_find ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.scan_hit || i_stat.scan_last) begin
                    o_cmd.scan_finish = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/dbam_dp.sv
// Datapath: track entry RAM with per-entry valid bits, running free total,
// operation logic, search check and result register.
// Depends on dbam_pkg and dbam_ram.
`default_nettype none

module dbam_dp
    import dbam_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_item    i_item,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat,
    output t_result       o_result,
    output logic          o_valid
);

    t_item                r_item;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [IDX_W-1:0]     r_scan_idx;
    logic [TRACK_LIMIT-1:0] r_vld;
    logic [TOT_W-1:0]     r_total;
    t_result              r_result;
    logic                 r_out_vld;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [ENTRY_W-1:0]   ram_q;
    logic [ENTRY_W-1:0]   rd_entry;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_entry;

    logic                 in_range_port;
    logic                 in_range;
    logic                 bad;
    logic [CNT_W-1:0]     old_cnt;
    logic [MAP_BITS-1:0]  old_bm;
    logic [CNT_W-1:0]     new_cnt;
    logic [MAP_BITS-1:0]  new_bm;
    logic [MAP_BITS-1:0]  sec_bit;
    logic [TOT_W-1:0]     n_total;
    t_result              exec_res;
    t_result              scan_res;

    logic [MAP_BITS-1:0]  cand;
    logic [MAP_BITS-1:0]  low_bit;
    logic [SEC_W-1:0]     hit_sec;
    logic [TRK_W-1:0]     chk_track;

    assign in_range_port = (i_item.track != '0) && (i_item.track <= TRK_W'(TRACK_LIMIT));
    assign in_range      = (r_item.track != '0) && (r_item.track <= TRK_W'(TRACK_LIMIT));

    // Read port: first read at accept, then one track entry per search step.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_scan_idx;
        if (i_cmd.accept) begin
            if (i_item.kind == KIND_FIND) begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end else begin
                rd_en   = in_range_port;
                rd_addr = IDX_W'(i_item.track - TRK_W'(1));
            end
        end else if (i_cmd.scan_step) begin
            rd_en = 1'b1;
        end
    end

    dbam_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TRACK_LIMIT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_rd_idx),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Never-written entries read as zero
    assign rd_entry = r_vld[r_rd_idx] ? ram_q : '0;
    assign old_cnt  = rd_entry[ENTRY_W-1 -: CNT_W];
    assign old_bm   = rd_entry[MAP_BITS-1:0];
    assign sec_bit  = MAP_BITS'(1) << r_item.sector;

    always_comb begin
        bad      = !in_range ||
                   ((r_item.kind != KIND_LOAD) && (r_item.sector >= SEC_W'(MAP_BITS)));
        new_cnt  = old_cnt;
        new_bm   = old_bm;
        wr_en    = 1'b0;
        exec_res = '0;
        case (r_item.kind)
            KIND_ALLOC: begin
                if (old_cnt != '0) begin
                    new_bm  = old_bm & ~sec_bit;
                    new_cnt = old_cnt - CNT_W'(1);
                end
            end
            KIND_FREE: begin
                if (old_cnt != '1) begin
                    new_bm  = old_bm | sec_bit;
                    new_cnt = old_cnt + CNT_W'(1);
                end
            end
            KIND_LOAD: begin
                case (r_item.load_index)
                    LIDX_COUNT: new_cnt       = r_item.load_value;
                    LIDX_BYTE0: new_bm[7:0]   = r_item.load_value;
                    LIDX_BYTE1: new_bm[15:8]  = r_item.load_value;
                    LIDX_BYTE2: new_bm[23:16] = r_item.load_value;
                    default:    new_cnt       = old_cnt;
                endcase
            end
            default: begin
                new_cnt = old_cnt;
            end
        endcase
        wr_entry = {new_cnt, new_bm};

        if (r_item.kind > KIND_LOAD) begin
            exec_res.status = ST_OK;
        end else if (bad) begin
            exec_res.status = ST_RANGE;
        end else begin
            exec_res.status = ST_OK;
            if (r_item.sector < SEC_W'(MAP_BITS)) begin
                exec_res.is_free = new_bm[r_item.sector];
            end
            exec_res.track_free_count = new_cnt;
            wr_en = i_cmd.exec && ((r_item.kind == KIND_ALLOC) ||
                                   (r_item.kind == KIND_FREE)  ||
                                   (r_item.kind == KIND_LOAD));
        end

        n_total = r_total;
        if (wr_en) begin
            n_total = r_total - TOT_W'(old_cnt) + TOT_W'(new_cnt);
        end
        exec_res.total_free = n_total;
    end

    // Search check on the entry that just came out of the RAM
    assign chk_track = TRK_W'(r_rd_idx) + TRK_W'(1);
    assign cand      = old_bm & zone_mask(chk_track);
    assign low_bit   = cand & (~cand + MAP_BITS'(1));

    always_comb begin
        hit_sec = '0;
        for (int i = 0; i < MAP_BITS; i++) begin
            if (low_bit[i]) begin
                hit_sec = hit_sec | SEC_W'(i);
            end
        end
    end

    always_comb begin
        scan_res            = '0;
        scan_res.total_free = r_total;
        if (cand != '0) begin
            scan_res.status           = ST_OK;
            scan_res.is_free          = 1'b1;
            scan_res.found_track      = chk_track;
            scan_res.found_sector     = hit_sec;
            scan_res.track_free_count = old_cnt;
        end else begin
            scan_res.status = ST_NOFREE;
        end
    end

    assign o_stat.in_find   = (i_item.kind == KIND_FIND);
    assign o_stat.scan_hit  = (cand != '0);
    assign o_stat.scan_last = (r_rd_idx == IDX_W'(TRACK_LIMIT - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        if (rd_en) begin
            r_rd_idx <= rd_addr;
        end
        if (i_cmd.accept) begin
            r_scan_idx <= IDX_W'(1);
        end else if (i_cmd.scan_step) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        if (i_cmd.exec) begin
            r_result <= exec_res;
        end else if (i_cmd.scan_finish) begin
            r_result <= scan_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[r_rd_idx] <= 1'b1;
            end
            r_total   <= n_total;
            r_out_vld <= i_cmd.exec || i_cmd.scan_finish;
        end
    end

    assign o_result = r_result;
    assign o_valid  = r_out_vld;

endmodule

`default_nettype wire

>>> rtl/core/disk_block_availability_map_top.sv
// Disk block availability map. Query/allocate/free/load: entry read at accept,
// operation applied in the execute state, result registered for the strobe.
// Find: one RAM read per track entry until a hit or the last track is checked.
// busy stays low in the strobe cycle, so the next item may start there.
// Synchronous reset clears the valid bits and the free total.
// Depends on dbam_pkg, dbam_ctrl, dbam_dp, dbam_ram.
`default_nettype none

module disk_block_availability_map_top
    import dbam_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_item i_item,
    output t_result    o_result,
    output logic       o_valid
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dbam_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    dbam_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

`ifndef SYNTH
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_find_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.found_track != '0) |->
            (o_result.is_free && o_result.status == ST_OK))
        else $error("found track without free sector");

    a_nofree_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_NOFREE) |->
            (o_result.track_free_count == '0 && !o_result.is_free))
        else $error("failed search carries data");
`endif

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Testbench for disk_block_availability_map_top: a model of the per-track map
// predicts each result and a monitor checks every strobed result in order.
// Depends on dbam_pkg and the block's RTL.

module tb_top;
    import dbam_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int NUM_KINDS   = 8;
    localparam int ITEM_TARGET = 1550;
    localparam int DRAIN_LIMIT = 2000;
    localparam int SETTLE      = 40;
    localparam int RUN_LIMIT   = 12_000_000;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    t_result o_result;
    logic    o_valid;

    // model of the map
    logic [CNT_W-1:0]    map_count [TRACK_LIMIT];
    logic [MAP_BITS-1:0] map_bits  [TRACK_LIMIT];
    logic [TOT_W-1:0]    map_total;

    t_result due_results[$];
    int      errors;
    int      items_sent;
    bit      gaps_on;

    disk_block_availability_map_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    initial begin
        #RUN_LIMIT;
        $display("status: fail");
        $finish;
    end

    function automatic int sectors_on(input int trk);
        if (trk < 18) return 21;
        if (trk < 25) return 19;
        if (trk < 31) return 18;
        return 17;
    endfunction

    function automatic void put_count(input int idx, input logic [CNT_W-1:0] c);
        map_total      = map_total - TOT_W'(map_count[idx]) + TOT_W'(c);
        map_count[idx] = c;
    endfunction

    // Applies one item to the map model and returns the result it must produce.
    function automatic t_result apply_map_op(input t_item it);
        t_result r;
        int      idx;
        int      t;
        int      s;
        bit      hit;
        r   = '0;
        hit = 1'b0;
        if (it.kind == KIND_FIND) begin
            for (t = 1; t <= TRACK_LIMIT && !hit; t++) begin
                if (t == DIR_TRACK) continue;
                for (s = 0; s < sectors_on(t); s++) begin
                    if (map_bits[t-1][s]) begin
                        hit            = 1'b1;
                        r.found_track  = TRK_W'(t);
                        r.found_sector = SEC_W'(s);
                        break;
                    end
                end
            end
            if (hit) begin
                r.status           = ST_OK;
                r.is_free          = 1'b1;
                r.track_free_count = map_count[int'(r.found_track) - 1];
            end else begin
                r.status = ST_NOFREE;
            end
        end else if (it.kind <= KIND_LOAD) begin
            if (it.track == 0 || it.track > TRACK_LIMIT ||
                (it.kind != KIND_LOAD && it.sector >= MAP_BITS)) begin
                r.status = ST_RANGE;
            end else begin
                idx = int'(it.track) - 1;
                case (it.kind)
                    KIND_ALLOC: begin
                        // count moves even if the bit was already clear
                        if (map_count[idx] != '0) begin
                            map_bits[idx][it.sector] = 1'b0;
                            put_count(idx, map_count[idx] - 1'b1);
                        end
                    end
                    KIND_FREE: begin
                        if (map_count[idx] != '1) begin
                            map_bits[idx][it.sector] = 1'b1;
                            put_count(idx, map_count[idx] + 1'b1);
                        end
                    end
                    KIND_LOAD: begin
                        if (it.load_index == LIDX_COUNT)
                            put_count(idx, it.load_value);
                        else
                            map_bits[idx][(int'(it.load_index) - 1) * 8 +: 8] = it.load_value;
                    end
                    default: ;
                endcase
                if (it.sector < MAP_BITS) r.is_free = map_bits[idx][it.sector];
                r.track_free_count = map_count[idx];
            end
        end
        r.total_free = map_total;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want) report_mismatch(name, got, want);
    endtask

    // Predict on accept, check on strobe. Outputs are read before this edge's updates.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (start && !busy) due_results.push_back(apply_map_op(i_item));
            if (o_valid) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing pending", o_result, 0);
                end else begin
                    want = due_results.pop_front();
                    check_field("status", o_result.status, want.status);
                    check_field("is_free", o_result.is_free, want.is_free);
                    check_field("found_track", o_result.found_track, want.found_track);
                    check_field("found_sector", o_result.found_sector, want.found_sector);
                    check_field("track_free_count", o_result.track_free_count,
                                want.track_free_count);
                    check_field("total_free", o_result.total_free, want.total_free);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_item mk_item(input logic [2:0] kind, input int trk, input int sec,
                                      input logic [1:0] lidx, input logic [7:0] lval);
        t_item it;
        it.kind       = kind;
        it.track      = TRK_W'(trk);
        it.sector     = SEC_W'(sec);
        it.load_index = lidx;
        it.load_value = lval;
        return it;
    endfunction

    // Drives one item from a falling edge and returns at the edge that takes it.
    task automatic send_item(input t_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic test_empty_map();
        send_item(mk_item(KIND_FIND, 0, 0, LIDX_COUNT, 8'h00));
    endtask

    task automatic test_range_errors();
        send_item(mk_item(KIND_QUERY, 0, 0, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_QUERY, TRACK_LIMIT + 1, 0, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_ALLOC, 63, 5, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_FREE, 5, MAP_BITS, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_QUERY, TRACK_LIMIT, 31, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_LOAD, 0, 0, LIDX_COUNT, 8'hFF));
    endtask

    task automatic test_count_limits();
        send_item(mk_item(KIND_FREE, 1, 0, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_ALLOC, 1, 0, LIDX_COUNT, 8'h00));
        // count already zero: nothing moves
        send_item(mk_item(KIND_ALLOC, 1, 3, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_LOAD, TRACK_LIMIT, 23, LIDX_COUNT, 8'hFF));
        send_item(mk_item(KIND_FREE, TRACK_LIMIT, 23, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_ALLOC, TRACK_LIMIT, 23, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_FREE, TRACK_LIMIT, 23, LIDX_COUNT, 8'h00));
        send_item(mk_item(KIND_LOAD, TRACK_LIMIT, 23, LIDX_COUNT, 8'h00));
    endtask

    task automatic test_load_and_find();
        // directory track bits never count for the search
        send_item(mk_item(KIND_LOAD, DIR_TRACK, 0, LIDX_BYTE0, 8'hFF));
        send_item(mk_item(KIND_LOAD, 2, 31, LIDX_BYTE1, 8'hFF));
        send_item(mk_item(KIND_LOAD, 2, 9, LIDX_BYTE1, 8'h00));
        send_item(mk_item(KIND_LOAD, 30, 16, LIDX_BYTE2, 8'h01));
        send_item(mk_item(KIND_FIND, 63, 31, LIDX_BYTE2, 8'hFF));
        send_item(mk_item(KIND_LOAD, 30, 0, LIDX_BYTE2, 8'h00));
        // only directory track bits and bits past the zone's sector count remain
        send_item(mk_item(KIND_FIND, 0, 0, LIDX_COUNT, 8'h00));
    endtask

    task automatic test_unused_kinds();
        for (int k = int'(KIND_LOAD) + 1; k < NUM_KINDS; k++)
            send_item(mk_item(3'(k), 1, 0, LIDX_COUNT, 8'hFF));
    endtask

    function automatic t_item make_random_op(input int lo);
        t_item it;
        int    r;
        int    pick;
        it = t_item'($urandom);
        r  = $urandom_range(0, 99);
        if (r < 8) return it;  // noise: any field value
        pick = $urandom_range(0, 99);
        if (pick < 20)      it.kind = KIND_QUERY;
        else if (pick < 45) it.kind = KIND_ALLOC;
        else if (pick < 70) it.kind = KIND_FREE;
        else if (pick < 85) it.kind = KIND_FIND;
        else                it.kind = KIND_LOAD;
        it.track  = TRK_W'($urandom_range(lo, TRACK_LIMIT));
        it.sector = SEC_W'($urandom_range(0, MAP_BITS - 1));
        if (it.kind == KIND_LOAD && it.load_index == LIDX_COUNT) begin
            case ($urandom_range(0, 4))
                0: it.load_value = 8'h00;
                1: it.load_value = 8'h01;
                2: it.load_value = 8'hFE;
                3: it.load_value = 8'hFF;
                default: ;
            endcase
        end
        return it;
    endfunction

    // Rounds: optionally wipe the low tracks so the search reaches deeper, then
    // random operations aimed at the tracks above.
    task automatic test_random_ops();
        int lo;
        int n;
        while (items_sent < ITEM_TARGET) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            lo      = $urandom_range(1, TRACK_LIMIT);
            if ($urandom_range(0, 1)) begin
                for (int t = 1; t < lo; t++) begin
                    send_item(mk_item(KIND_LOAD, t, 0, LIDX_BYTE0, 8'h00));
                    send_item(mk_item(KIND_LOAD, t, 0, LIDX_BYTE1, 8'h00));
                    send_item(mk_item(KIND_LOAD, t, 0, LIDX_BYTE2, 8'h00));
                end
                send_item(mk_item(KIND_FIND, 0, 0, LIDX_COUNT, 8'h00));
            end else begin
                lo = 1;
            end
            n = $urandom_range(20, 60);
            repeat (n) send_item(make_random_op(lo));
        end
    endtask

    initial begin
        int drain;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        errors     = 0;
        items_sent = 0;
        gaps_on    = 1'b1;
        map_total  = '0;
        foreach (map_count[i]) begin
            map_count[i] = '0;
            map_bits[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_map();
        test_range_errors();
        test_count_limits();
        test_load_and_find();
        test_unused_kinds();
        test_random_ops();

        @(negedge i_clk);
        start <= 1'b0;
        drain = 0;
        while (due_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch("results never arrived", due_results.size(), 0);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dbam_pkg.sv
rtl/core/dbam_ram.sv
rtl/core/dbam_ctrl.sv
rtl/core/dbam_dp.sv
rtl/core/disk_block_availability_map_top.sv
sim/tb_top.sv
